// File: design/wfr_pkg.sv
package wfr_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int LEN_W       = 7;

  localparam logic OPC_BYTE    = 1'b0;
  localparam logic OPC_RESTART = 1'b1;

  localparam logic [3:0] FT_TEXT  = 4'h1;
  localparam logic [3:0] FT_CLOSE = 4'h8;
  localparam logic [3:0] FT_PING  = 4'h9;
  localparam logic [3:0] FT_PONG  = 4'hA;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_MASK0   = 3'd2,
    PH_MASK1   = 3'd3,
    PH_MASK2   = 3'd4,
    PH_MASK3   = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    EM_IDLE = 2'd0,
    EM_READ = 2'd1,
    EM_LOAD = 2'd2
  } em_state_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_REPLY   = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_TEXT     = 3'd0,
    ST_PING     = 3'd1,
    ST_PONG     = 3'd2,
    ST_CLOSE    = 3'd3,
    ST_OVERSIZE = 3'd4,
    ST_FRAGMENT = 3'd5,
    ST_UNKNOWN  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    RP_NONE  = 2'd0,
    RP_PONG  = 2'd1,
    RP_CLOSE = 2'd2,
    RP_ERROR = 2'd3
  } reply_t;

  typedef struct packed {
    kind_t             kind;
    status_t           status;
    logic              drop;
    logic [LEN_W-1:0]  count;
    reply_t            reply;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  function automatic logic [7:0] reply_byte(reply_t sel, logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (sel)
      RP_PONG: b = (idx == 2'd0) ? 8'h8A : 8'h00;
      RP_CLOSE: b = (idx == 2'd0) ? 8'h08 : 8'h00;
      RP_ERROR: begin
        case (idx)
          2'd0: b = 8'h08;
          2'd1: b = 8'h02;
          2'd2: b = 8'h03;
          default: b = 8'hF1;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: design/wfr_payload_ram.sv
module wfr_payload_ram (
  input  logic                       clk,
  input  wfr_pkg::wr_t               wr,
  input  logic [wfr_pkg::ADDR_W-1:0] rd_addr,
  output logic [7:0]                 rd_data
);

  logic [7:0] mem [wfr_pkg::MAX_PAYLOAD];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/wfr_parser.sv
module wfr_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_acc,
  input  logic          opcode,
  input  logic [7:0]    rx_byte,
  output wfr_pkg::wr_t  wr,
  output logic          job_vld,
  output wfr_pkg::job_t job
);

  localparam logic [wfr_pkg::LEN_W-1:0] MAX_LEN = wfr_pkg::LEN_W'(wfr_pkg::MAX_PAYLOAD);

  wfr_pkg::phase_t             phase_r, phase_nxt;
  logic                        final_r;
  logic [3:0]                  ftype_r;
  logic                        masked_r;
  logic [wfr_pkg::LEN_W-1:0]   len_r;
  logic [7:0]                  mask_r [4];
  logic [wfr_pkg::LEN_W-1:0]   cnt_r;
  logic                        dead_r;

  logic                        byte_ok;
  logic                        restart;
  logic [wfr_pkg::LEN_W-1:0]   cnt_inc;
  logic [wfr_pkg::LEN_W-1:0]   new_len;
  logic [wfr_pkg::LEN_W-1:0]   fin_len;
  logic                        oversize;
  logic                        pay_done;
  wfr_pkg::job_t               fin_job;
  wfr_pkg::job_t               err_job;

  assign restart  = in_acc && (opcode == wfr_pkg::OPC_RESTART);
  assign byte_ok  = in_acc && (opcode == wfr_pkg::OPC_BYTE) && !dead_r;
  assign cnt_inc  = cnt_r + wfr_pkg::LEN_W'(1);
  assign new_len  = rx_byte[6:0];
  assign oversize = new_len > MAX_LEN;
  assign pay_done = cnt_inc >= len_r;
  // a frame ending on its length byte has not stored that length yet
  assign fin_len  = (phase_r == wfr_pkg::PH_LENGTH) ? new_len : len_r;

  // what the frame asks for once it is complete
  always_comb begin
    fin_job = '{kind: wfr_pkg::KIND_STATUS, status: wfr_pkg::ST_UNKNOWN, drop: 1'b1,
                count: wfr_pkg::LEN_W'(1), reply: wfr_pkg::RP_NONE};
    if (!final_r) begin
      fin_job = '{kind: wfr_pkg::KIND_REPLY, status: wfr_pkg::ST_FRAGMENT, drop: 1'b1,
                  count: wfr_pkg::LEN_W'(4), reply: wfr_pkg::RP_ERROR};
    end else begin
      case (ftype_r)
        wfr_pkg::FT_TEXT: begin
          if (fin_len == '0) begin
            fin_job = '{kind: wfr_pkg::KIND_STATUS, status: wfr_pkg::ST_TEXT, drop: 1'b0,
                        count: wfr_pkg::LEN_W'(1), reply: wfr_pkg::RP_NONE};
          end else begin
            fin_job = '{kind: wfr_pkg::KIND_PAYLOAD, status: wfr_pkg::ST_TEXT, drop: 1'b0,
                        count: fin_len, reply: wfr_pkg::RP_NONE};
          end
        end
        wfr_pkg::FT_PING: begin
          fin_job = '{kind: wfr_pkg::KIND_REPLY, status: wfr_pkg::ST_PING, drop: 1'b0,
                      count: wfr_pkg::LEN_W'(2), reply: wfr_pkg::RP_PONG};
        end
        wfr_pkg::FT_PONG: begin
          fin_job = '{kind: wfr_pkg::KIND_STATUS, status: wfr_pkg::ST_PONG, drop: 1'b0,
                      count: wfr_pkg::LEN_W'(1), reply: wfr_pkg::RP_NONE};
        end
        wfr_pkg::FT_CLOSE: begin
          fin_job = '{kind: wfr_pkg::KIND_REPLY, status: wfr_pkg::ST_CLOSE, drop: 1'b1,
                      count: wfr_pkg::LEN_W'(2), reply: wfr_pkg::RP_CLOSE};
        end
        default: begin
          fin_job = '{kind: wfr_pkg::KIND_STATUS, status: wfr_pkg::ST_UNKNOWN, drop: 1'b1,
                      count: wfr_pkg::LEN_W'(1), reply: wfr_pkg::RP_NONE};
        end
      endcase
    end
  end

  assign err_job = '{kind: wfr_pkg::KIND_REPLY, status: wfr_pkg::ST_OVERSIZE, drop: 1'b1,
                     count: wfr_pkg::LEN_W'(4), reply: wfr_pkg::RP_ERROR};

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (restart) begin
      phase_nxt = wfr_pkg::PH_HEADER;
    end else if (byte_ok) begin
      case (phase_r)
        wfr_pkg::PH_LENGTH: begin
          if (oversize || (!rx_byte[7] && new_len == '0)) begin
            phase_nxt = wfr_pkg::PH_HEADER;
          end else if (rx_byte[7]) begin
            phase_nxt = wfr_pkg::PH_MASK0;
          end else begin
            phase_nxt = wfr_pkg::PH_PAYLOAD;
          end
        end
        wfr_pkg::PH_MASK0: phase_nxt = wfr_pkg::PH_MASK1;
        wfr_pkg::PH_MASK1: phase_nxt = wfr_pkg::PH_MASK2;
        wfr_pkg::PH_MASK2: phase_nxt = wfr_pkg::PH_MASK3;
        wfr_pkg::PH_MASK3: begin
          phase_nxt = (len_r == '0) ? wfr_pkg::PH_HEADER : wfr_pkg::PH_PAYLOAD;
        end
        wfr_pkg::PH_PAYLOAD: begin
          if (pay_done) begin
            phase_nxt = wfr_pkg::PH_HEADER;
          end
        end
        default: phase_nxt = wfr_pkg::PH_LENGTH;
      endcase
    end
  end

  // frame-end job and payload write
  always_comb begin
    job_vld = 1'b0;
    job     = fin_job;
    wr.en   = 1'b0;
    wr.addr = cnt_r[wfr_pkg::ADDR_W-1:0];
    wr.data = masked_r ? (rx_byte ^ mask_r[cnt_r[1:0]]) : rx_byte;
    if (byte_ok) begin
      case (phase_r)
        wfr_pkg::PH_LENGTH: begin
          if (oversize) begin
            job_vld = 1'b1;
            job     = err_job;
          end else if (!rx_byte[7] && new_len == '0) begin
            job_vld = 1'b1;
          end
        end
        wfr_pkg::PH_MASK3: begin
          job_vld = (len_r == '0);
        end
        wfr_pkg::PH_PAYLOAD: begin
          wr.en   = cnt_r < MAX_LEN;
          job_vld = pay_done;
        end
        default: begin
          job_vld = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      phase_r  <= wfr_pkg::PH_HEADER;
      final_r  <= 1'b0;
      ftype_r  <= '0;
      masked_r <= 1'b0;
      len_r    <= '0;
      cnt_r    <= '0;
      dead_r   <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        mask_r[i] <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      if (job_vld && job.drop) begin
        dead_r <= 1'b1;
      end
      if (byte_ok) begin
        case (phase_r)
          wfr_pkg::PH_LENGTH: begin
            len_r    <= new_len;
            masked_r <= rx_byte[7];
            cnt_r    <= '0;
          end
          wfr_pkg::PH_MASK0: mask_r[0] <= rx_byte;
          wfr_pkg::PH_MASK1: mask_r[1] <= rx_byte;
          wfr_pkg::PH_MASK2: mask_r[2] <= rx_byte;
          wfr_pkg::PH_MASK3: mask_r[3] <= rx_byte;
          wfr_pkg::PH_PAYLOAD: cnt_r <= cnt_inc;
          default: begin
            ftype_r <= rx_byte[3:0];
            final_r <= rx_byte[7];
          end
        endcase
      end
    end
  end

endmodule

// File: design/wfr_emitter.sv
module wfr_emitter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       job_vld,
  input  wfr_pkg::job_t              job,
  output logic [wfr_pkg::ADDR_W-1:0] rd_addr,
  input  logic [7:0]                 rd_data,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_kind,
  output logic [7:0]                 out_byte,
  output logic                       out_last,
  output logic [2:0]                 out_frame_status,
  output logic                       out_drop_connection
);

  wfr_pkg::em_state_t        state_r, state_nxt;
  wfr_pkg::job_t             job_r;
  logic [wfr_pkg::LEN_W-1:0] idx_r;

  logic                      out_valid_r;
  wfr_pkg::kind_t            out_kind_r;
  logic [7:0]                out_byte_r;
  logic                      out_last_r;
  wfr_pkg::status_t          out_status_r;
  logic                      out_drop_r;

  logic                      out_free;
  logic                      is_last;
  logic                      load;
  logic [7:0]                cur_byte;

  assign out_free = !out_valid_r || !out_stall;
  assign is_last  = idx_r == (job_r.count - wfr_pkg::LEN_W'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wfr_pkg::EM_IDLE: begin
        if (job_vld) begin
          state_nxt = wfr_pkg::EM_READ;
        end
      end
      wfr_pkg::EM_READ: state_nxt = wfr_pkg::EM_LOAD;
      wfr_pkg::EM_LOAD: begin
        if (out_free) begin
          state_nxt = is_last ? wfr_pkg::EM_IDLE : wfr_pkg::EM_READ;
        end
      end
      default: state_nxt = wfr_pkg::EM_IDLE;
    endcase
  end

  always_comb begin
    busy    = state_r != wfr_pkg::EM_IDLE;
    load    = (state_r == wfr_pkg::EM_LOAD) && out_free;
    rd_addr = idx_r[wfr_pkg::ADDR_W-1:0];
    case (job_r.kind)
      wfr_pkg::KIND_PAYLOAD: cur_byte = rd_data;
      wfr_pkg::KIND_REPLY: cur_byte = wfr_pkg::reply_byte(job_r.reply, idx_r[1:0]);
      default: cur_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wfr_pkg::EM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == wfr_pkg::EM_IDLE && job_vld) begin
      job_r <= job;
      idx_r <= '0;
    end else if (load) begin
      idx_r <= idx_r + wfr_pkg::LEN_W'(1);
    end
    if (load) begin
      out_kind_r   <= job_r.kind;
      out_byte_r   <= cur_byte;
      out_last_r   <= is_last;
      // status and drop only ride on the closing item
      out_status_r <= is_last ? job_r.status : wfr_pkg::ST_TEXT;
      out_drop_r   <= is_last && job_r.drop;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_byte            = out_byte_r;
  assign out_last            = out_last_r;
  assign out_frame_status    = out_status_r;
  assign out_drop_connection = out_drop_r;

endmodule

// File: design/websocket_frame_receiver.sv
// one received byte per cycle while no frame results are pending
// frame results begin after the ending byte; each result takes a payload ram read, then
// a load into the output register, which waits while out_stall holds a valid output
// input is stalled from the cycle after a frame ends until its last result is loaded
// rst_n is synchronous, active low, clears parser and output control
// payload ram is not cleared; only bytes written in the current frame are replayed
module websocket_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic [2:0] out_frame_status,
  output logic       out_drop_connection
);

  logic                       in_acc;
  logic                       busy;
  logic                       job_vld;
  wfr_pkg::job_t              job;
  wfr_pkg::wr_t               wr;
  logic [wfr_pkg::ADDR_W-1:0] rd_addr;
  logic [7:0]                 rd_data;

  assign in_stall = busy;
  assign in_acc   = in_valid && !in_stall;

  wfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .opcode  (in_opcode),
    .rx_byte (in_rx_byte),
    .wr      (wr),
    .job_vld (job_vld),
    .job     (job)
  );

  wfr_payload_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wfr_emitter u_emitter (
    .clk                 (clk),
    .rst_n               (rst_n),
    .job_vld             (job_vld),
    .job                 (job),
    .rd_addr             (rd_addr),
    .rd_data             (rd_data),
    .busy                (busy),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_byte            (out_byte),
    .out_last            (out_last),
    .out_frame_status    (out_frame_status),
    .out_drop_connection (out_drop_connection)
  );

  a_job_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_vld |-> !busy)
    else $error("frame job issued while results still pending");

  a_no_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> !busy)
    else $error("payload write during replay");

  a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |->
      (out_frame_status == wfr_pkg::ST_TEXT && !out_drop_connection))
    else $error("status or drop on a non-final item");

  a_busy_after_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_vld |=> busy)
    else $error("emitter did not start on a frame job");

endmodule

// File: bench/tb_top.sv
module tb_top;

  localparam int LIMIT        = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int N_SCRIPT     = 27;

  localparam logic [31:0] ERR_REPLY   = 32'h0802_03F1;
  localparam logic [31:0] PONG_REPLY  = 32'h8A00_0000;
  localparam logic [31:0] CLOSE_REPLY = 32'h0800_0000;

  typedef struct packed {
    wfr_pkg::kind_t   kind;
    logic [7:0]       data;
    logic             last;
    wfr_pkg::status_t status;
    logic             drop;
  } frame_result_t;

  // n == 0: results come from the parser model, else typed in the row
  typedef struct packed {
    logic             opc;
    logic [7:0]       data;
    logic [2:0]       n;
    wfr_pkg::kind_t   kind;
    logic [31:0]      seq;
    wfr_pkg::status_t st;
    logic             drop;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_opcode = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;
  logic [2:0] out_frame_status;
  logic       out_drop_connection;

  websocket_frame_receiver uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_byte            (out_byte),
    .out_last            (out_last),
    .out_frame_status    (out_frame_status),
    .out_drop_connection (out_drop_connection)
  );

  always #5 clk = ~clk;

  // parser model state
  wfr_pkg::phase_t ph = wfr_pkg::PH_HEADER;
  logic       fin = 1'b0;
  logic [3:0] ftype = 4'h0;
  logic       masked = 1'b0;
  logic [6:0] plen = 7'd0;
  logic [7:0] mask_key [4];
  logic [6:0] cnt = 7'd0;
  logic [7:0] store [wfr_pkg::MAX_PAYLOAD];
  logic       dead = 1'b0;
  bit         quiet = 1'b0;

  frame_result_t frame_results_q [$];
  script_row_t   script [N_SCRIPT];

  int errors = 0;
  int n_items = 0;
  int n_ignored = 0;
  int n_results = 0;
  int n_frames = 0;
  int n_drops = 0;
  int cycles = 0;
  int snd_idle = 0;
  int rcv_stall = 0;
  int hold_gen = 0;
  int hold_seen = 0;
  int hold_left = 0;

  task report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0h expected %0h", n_results, what, got, want);
    errors++;
  endtask

  function void add_result(wfr_pkg::kind_t k, logic [7:0] d, logic last,
                           wfr_pkg::status_t st, logic drop);
    frame_result_t r;
    if (quiet) return;
    r.kind = k;
    r.data = d;
    r.last = last;
    r.status = last ? st : wfr_pkg::ST_TEXT;
    r.drop = last & drop;
    frame_results_q.push_back(r);
  endfunction

  // seq holds up to four bytes, first byte in the top lane
  function void queue_results(wfr_pkg::kind_t k, logic [31:0] seq, int n,
                              wfr_pkg::status_t st, logic drop);
    for (int i = 0; i < n; i++) add_result(k, seq[31-8*i -: 8], i == n - 1, st, drop);
  endfunction

  function void clear_parser();
    ph = wfr_pkg::PH_HEADER;
    fin = 1'b0;
    ftype = 4'h0;
    masked = 1'b0;
    plen = 7'd0;
    cnt = 7'd0;
    dead = 1'b0;
    for (int i = 0; i < 4; i++) mask_key[i] = 8'h00;
  endfunction

  function void close_frame();
    ph = wfr_pkg::PH_HEADER;
    if (!fin) begin
      // fragmentation is not supported, even for control types
      dead = 1'b1;
      queue_results(wfr_pkg::KIND_REPLY, ERR_REPLY, 4, wfr_pkg::ST_FRAGMENT, 1'b1);
    end else begin
      case (ftype)
        wfr_pkg::FT_TEXT: begin
          if (plen == 0) queue_results(wfr_pkg::KIND_STATUS, 32'h0, 1, wfr_pkg::ST_TEXT, 1'b0);
          else for (int i = 0; i < plen; i++)
            add_result(wfr_pkg::KIND_PAYLOAD, store[i], i == plen - 1, wfr_pkg::ST_TEXT, 1'b0);
        end
        wfr_pkg::FT_PING:
          queue_results(wfr_pkg::KIND_REPLY, PONG_REPLY, 2, wfr_pkg::ST_PING, 1'b0);
        wfr_pkg::FT_PONG:
          queue_results(wfr_pkg::KIND_STATUS, 32'h0, 1, wfr_pkg::ST_PONG, 1'b0);
        wfr_pkg::FT_CLOSE: begin
          dead = 1'b1;
          queue_results(wfr_pkg::KIND_REPLY, CLOSE_REPLY, 2, wfr_pkg::ST_CLOSE, 1'b1);
        end
        default: begin
          dead = 1'b1;
          queue_results(wfr_pkg::KIND_STATUS, 32'h0, 1, wfr_pkg::ST_UNKNOWN, 1'b1);
        end
      endcase
    end
  endfunction

  function void parse_rx_byte(logic opc, logic [7:0] b);
    if (opc == wfr_pkg::OPC_RESTART) begin
      clear_parser();
      return;
    end
    if (dead) return;
    case (ph)
      wfr_pkg::PH_LENGTH: begin
        plen = b[6:0];
        masked = b[7];
        cnt = 7'd0;
        if (plen > wfr_pkg::MAX_PAYLOAD) begin
          ph = wfr_pkg::PH_HEADER;
          dead = 1'b1;
          queue_results(wfr_pkg::KIND_REPLY, ERR_REPLY, 4, wfr_pkg::ST_OVERSIZE, 1'b1);
        end else if (masked) ph = wfr_pkg::PH_MASK0;
        else if (plen == 0) close_frame();
        else ph = wfr_pkg::PH_PAYLOAD;
      end
      wfr_pkg::PH_MASK0, wfr_pkg::PH_MASK1, wfr_pkg::PH_MASK2, wfr_pkg::PH_MASK3: begin
        mask_key[ph - wfr_pkg::PH_MASK0] = b;
        if (ph != wfr_pkg::PH_MASK3) ph = wfr_pkg::phase_t'(ph + 3'd1);
        else if (plen == 0) close_frame();
        else ph = wfr_pkg::PH_PAYLOAD;
      end
      wfr_pkg::PH_PAYLOAD: begin
        store[cnt] = masked ? (b ^ mask_key[cnt[1:0]]) : b;
        cnt = cnt + 7'd1;
        if (cnt >= plen) close_frame();
      end
      default: begin
        ftype = b[3:0];
        fin = b[7];
        ph = wfr_pkg::PH_LENGTH;
      end
    endcase
  endfunction

  // offer one item, wait for it to be taken, then update the model
  task send_item(input logic opc, input logic [7:0] b, input bit typed);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= opc;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (opc == wfr_pkg::OPC_RESTART || !dead) n_items++;
    else n_ignored++;
    quiet = typed;
    parse_rx_byte(opc, b);
    quiet = 1'b0;
  endtask

  task send_frame();
    int r, len;
    logic fin_bit, msk, oversize;
    logic [3:0] ft;
    logic [7:0] seq [$];
    if (dead) begin
      if ($urandom_range(0, 3) == 0) send_item(wfr_pkg::OPC_BYTE, 8'($urandom), 1'b0);
      send_item(wfr_pkg::OPC_RESTART, 8'($urandom), 1'b0);
    end else if ($urandom_range(0, 49) == 0) begin
      send_item(wfr_pkg::OPC_RESTART, 8'($urandom), 1'b0);
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      // line noise, sometimes followed by a fresh connection
      repeat ($urandom_range(1, 3)) send_item(wfr_pkg::OPC_BYTE, 8'($urandom), 1'b0);
      if ($urandom_range(0, 1) == 1) send_item(wfr_pkg::OPC_RESTART, 8'($urandom), 1'b0);
      return;
    end
    fin_bit = 1'b1;
    oversize = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 45) ft = wfr_pkg::FT_TEXT;
    else if (r < 60) ft = wfr_pkg::FT_PING;
    else if (r < 72) ft = wfr_pkg::FT_PONG;
    else if (r < 78) ft = wfr_pkg::FT_CLOSE;
    else if (r < 84) begin
      ft = 4'($urandom);
      while (ft == wfr_pkg::FT_TEXT || ft == wfr_pkg::FT_PING ||
             ft == wfr_pkg::FT_PONG || ft == wfr_pkg::FT_CLOSE)
        ft = 4'($urandom);
    end else if (r < 90) begin
      fin_bit = 1'b0;
      ft = 4'($urandom);
    end else begin
      ft = wfr_pkg::FT_TEXT;
      oversize = 1'b1;
    end
    if (oversize) len = $urandom_range(wfr_pkg::MAX_PAYLOAD + 1, 127);
    else if ($urandom_range(0, 39) == 0) len = wfr_pkg::MAX_PAYLOAD;
    else if ($urandom_range(0, 14) == 0) len = $urandom_range(9, wfr_pkg::MAX_PAYLOAD);
    else len = $urandom_range(0, 8);
    msk = ($urandom_range(0, 9) < 7);
    seq.push_back({fin_bit, 3'($urandom), ft});
    seq.push_back({msk, 7'(len)});
    if (!oversize) begin
      if (msk) repeat (4) seq.push_back(8'($urandom));
      repeat (len) seq.push_back(8'($urandom));
    end
    // now and then cut the frame short with a new connection
    if ($urandom_range(0, 19) == 0) begin
      r = $urandom_range(1, seq.size());
      while (seq.size() > r) void'(seq.pop_back());
      foreach (seq[i]) send_item(wfr_pkg::OPC_BYTE, seq[i], 1'b0);
      send_item(wfr_pkg::OPC_RESTART, 8'($urandom), 1'b0);
    end else begin
      foreach (seq[i]) send_item(wfr_pkg::OPC_BYTE, seq[i], 1'b0);
    end
  endtask

  task run_phase(input int idle_pct, input int stall_pct, input int upto);
    snd_idle = idle_pct;
    rcv_stall = stall_pct;
    while (n_items < upto) send_frame();
  endtask

  // result side: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen <= hold_gen;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_stall);
    end
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_results_q.size() == 0) begin
        report_mismatch("unexpected result, byte", out_byte, 0);
      end else begin
        want = frame_results_q.pop_front();
        if (out_kind != want.kind) report_mismatch("kind", out_kind, want.kind);
        if (out_byte != want.data) report_mismatch("byte", out_byte, want.data);
        if (out_last != want.last) report_mismatch("last", out_last, want.last);
        if (out_frame_status != want.status)
          report_mismatch("status", out_frame_status, want.status);
        if (out_drop_connection != want.drop)
          report_mismatch("drop", out_drop_connection, want.drop);
      end
      n_results++;
      if (out_last) n_frames++;
      if (out_last && out_drop_connection) n_drops++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, frame_results_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clear_parser();
    script = '{
      // empty unmasked text frame ends on the length byte
      '{wfr_pkg::OPC_BYTE,    8'h81, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_BYTE,    8'h00, 3'd1, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      // masked empty ping ends on the last mask byte
      '{wfr_pkg::OPC_BYTE,    8'h89, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_BYTE,    8'h80, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_BYTE,    8'h11, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_BYTE,    8'h22, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_BYTE,    8'h33, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_BYTE,    8'h44, 3'd2, wfr_pkg::KIND_REPLY,  PONG_REPLY,
        wfr_pkg::ST_PING,     1'b0},
      // unmasked text, payload passes through as is
      '{wfr_pkg::OPC_BYTE,    8'h81, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_BYTE,    8'h02, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_BYTE,    8'hFF, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_BYTE,    8'h00, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_BYTE,    8'h8A, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_BYTE,    8'h00, 3'd1, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_PONG,     1'b0},
      // largest length with mask bit set
      '{wfr_pkg::OPC_BYTE,    8'h81, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_BYTE,    8'hFF, 3'd4, wfr_pkg::KIND_REPLY,  ERR_REPLY,
        wfr_pkg::ST_OVERSIZE, 1'b1},
      // dropped connection ignores bytes
      '{wfr_pkg::OPC_BYTE,    8'hFF, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_RESTART, 8'h00, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_BYTE,    8'h01, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_BYTE,    8'h00, 3'd4, wfr_pkg::KIND_REPLY,  ERR_REPLY,
        wfr_pkg::ST_FRAGMENT, 1'b1},
      '{wfr_pkg::OPC_RESTART, 8'hFF, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_BYTE,    8'h88, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_BYTE,    8'h00, 3'd2, wfr_pkg::KIND_REPLY,  CLOSE_REPLY,
        wfr_pkg::ST_CLOSE,    1'b1},
      '{wfr_pkg::OPC_RESTART, 8'h00, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_BYTE,    8'h8F, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0},
      '{wfr_pkg::OPC_BYTE,    8'h00, 3'd1, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_UNKNOWN,  1'b1},
      '{wfr_pkg::OPC_RESTART, 8'h00, 3'd0, wfr_pkg::KIND_STATUS, 32'h0,
        wfr_pkg::ST_TEXT,     1'b0}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_SCRIPT; i++) begin
      send_item(script[i].opc, script[i].data, script[i].n != 0);
      if (script[i].n != 0)
        queue_results(script[i].kind, script[i].seq, script[i].n, script[i].st, script[i].drop);
    end

    run_phase(0, 0, 70);

    // hold the result side off while a full-size frame and pings keep coming
    snd_idle = 0;
    rcv_stall = 0;
    hold_gen <= hold_gen + 1;
    if (dead) send_item(wfr_pkg::OPC_RESTART, 8'($urandom), 1'b0);
    send_item(wfr_pkg::OPC_BYTE, {1'b1, 3'b000, wfr_pkg::FT_TEXT}, 1'b0);
    send_item(wfr_pkg::OPC_BYTE, {1'b1, 7'(wfr_pkg::MAX_PAYLOAD)}, 1'b0);
    repeat (4 + wfr_pkg::MAX_PAYLOAD) send_item(wfr_pkg::OPC_BYTE, 8'($urandom), 1'b0);
    repeat (3) begin
      send_item(wfr_pkg::OPC_BYTE, {1'b1, 3'b000, wfr_pkg::FT_PING}, 1'b0);
      send_item(wfr_pkg::OPC_BYTE, 8'h00, 1'b0);
    end

    run_phase(85, 0, 170);
    run_phase(0, 85, 215);
    run_phase(23, 23, 260);

    in_valid <= 1'b0;
    rcv_stall = 0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d items (%0d ignored on a dropped link) and %0d results in %0d frames",
             n_items, n_ignored, n_results, n_frames);
    $display("%0d frames dropped the link; idle mixes and a %0d cycle result hold-off included",
             n_drops, HOLD_CYCLES);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
